// ===== rtl/tchq_pkg.sv =====
// ----------------------------------------------------------------------------
// tchq_pkg
// Shared types and constants of the touch event qualifier.
// ----------------------------------------------------------------------------
package tchq_pkg;

    localparam int COORD_W = 12;
    localparam int OUT_W   = 13;
    localparam int ID_W    = 4;
    localparam int SIZE_W  = 16;
    localparam int DLY_W   = 8;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_MIRROR_ENABLE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd3;
    localparam logic [IDX_W-1:0] REG_POLL_MIN       = 3'd4;
    localparam logic [IDX_W-1:0] REG_POLL_MAX       = 3'd5;
    localparam logic [IDX_W-1:0] REG_POLL_STEP      = 3'd6;

    // Reset values of the registers
    localparam logic               MIRROR_RST    = 1'b1;
    localparam logic [COORD_W-1:0] WIDTH_RST     = 12'd1024;
    localparam logic [COORD_W-1:0] HEIGHT_RST    = 12'd600;
    localparam logic [7:0]         THRESHOLD_RST = 8'd4;
    localparam logic [DLY_W-1:0]   POLL_MIN_RST  = 8'd5;
    localparam logic [DLY_W-1:0]   POLL_MAX_RST  = 8'd30;
    localparam logic [DLY_W-1:0]   POLL_STEP_RST = 8'd5;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic               mirror_enable;
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
    } front_cfg_t;

    typedef struct packed {
        logic [7:0]       move_threshold;
        logic [DLY_W-1:0] poll_min;
        logic [DLY_W-1:0] poll_max;
        logic [DLY_W-1:0] poll_step;
    } back_cfg_t;

    // Classified poll, as held in the queue
    typedef struct packed {
        logic                    read_ok;
        logic                    qualified;
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic [ID_W-1:0]         id;
        logic [SIZE_W-1:0]       size;
    } q_item_t;

endpackage

// ===== rtl/touch_event_qualifier.sv =====
// ----------------------------------------------------------------------------
// touch_event_qualifier
// Turns touch controller polls into down / move / up events.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one poll per item: s_tuser is the read-success flag, s_tdata
//   the decoded status and first point. m_* returns exactly one result per
//   poll: m_tuser is the event kind, m_tdata the reported point and the
//   delay before the next poll.
//   cfg_we / cfg_index / cfg_data write a register at the clock edge; write
//   only while no poll is in flight.
//   Path: an accepted poll is written into the queue, then moves into the
//   output register when that register is free or being emptied; m_tvalid
//   and the result come from the output register.
//   Throughput: one poll per cycle while m_tready stays high; the tracker state
//   is registered on each pop and the two-entry queue decouples the sides.
//   Reset: registers take their default values, the tracker leaves the
//   touching state, the delay returns to its minimum, queue and output empty.
//   Stall: while m_tready is low the result holds; polls keep being taken
//   until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module touch_event_qualifier
    import tchq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,   // read_ok
    // buffer_ready, large_touch, point_count[3:0], point_x[11:0],
    // point_y[11:0], point_id[3:0], point_size[15:0]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [1:0]             m_tuser,   // event_kind
    // out_x[12:0], out_y[12:0], touch_id[3:0], pressure[15:0], poll_delay[7:0]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    front_cfg_t front_cfg_reg;
    back_cfg_t  back_cfg_reg;
    q_item_t    front_item;
    q_item_t    q_item;
    logic       q_valid;
    logic       q_pop;
    logic [1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.mirror_enable <= MIRROR_RST;
            front_cfg_reg.screen_width  <= WIDTH_RST;
            front_cfg_reg.screen_height <= HEIGHT_RST;
            back_cfg_reg.move_threshold <= THRESHOLD_RST;
            back_cfg_reg.poll_min       <= POLL_MIN_RST;
            back_cfg_reg.poll_max       <= POLL_MAX_RST;
            back_cfg_reg.poll_step      <= POLL_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIRROR_ENABLE:  front_cfg_reg.mirror_enable <= cfg_data[0];
                REG_SCREEN_WIDTH:   front_cfg_reg.screen_width  <= cfg_data;
                REG_SCREEN_HEIGHT:  front_cfg_reg.screen_height <= cfg_data;
                REG_MOVE_THRESHOLD: back_cfg_reg.move_threshold <= cfg_data[7:0];
                REG_POLL_MIN:       back_cfg_reg.poll_min       <= cfg_data[7:0];
                REG_POLL_MAX:       back_cfg_reg.poll_max       <= cfg_data[7:0];
                REG_POLL_STEP:      back_cfg_reg.poll_step      <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    tchq_front u_front (
        .read_ok (s_tuser),
        .tdata   (s_tdata),
        .cfg     (front_cfg_reg),
        .item    (front_item)
    );

    tchq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_item  (front_item),
        .push_ready (s_tready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .count      (q_count)
    );

    tchq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (back_cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count != 2'd3)
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (q_count != 2'd0))
        else $error("accepted item missing from queue");

    a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_tvalid)
        else $error("tracked item did not reach the output register");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == 2'd0) |-> !q_pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/tchq_front.sv =====
// ----------------------------------------------------------------------------
// tchq_front
// Decodes one poll, qualifies the touch and applies mirroring.
// ----------------------------------------------------------------------------
module tchq_front
    import tchq_pkg::*;
(
    input  logic                  read_ok,
    input  logic [IN_TDATA_W-1:0] tdata,
    input  front_cfg_t            cfg,
    output q_item_t               item
);

    logic               buffer_ready;
    logic               large_touch;
    logic [3:0]         point_count;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [OUT_W-1:0]   raw_x;
    logic [OUT_W-1:0]   raw_y;

    assign buffer_ready = tdata[0];
    assign large_touch  = tdata[1];
    assign point_count  = tdata[5:2];
    assign point_x      = tdata[17:6];
    assign point_y      = tdata[29:18];

    assign raw_x = {1'b0, point_x};
    assign raw_y = {1'b0, point_y};

    always_comb
    begin
        item.read_ok   = read_ok;
        item.qualified = buffer_ready && (point_count != 4'd0) && !large_touch;
        if (cfg.mirror_enable)
        begin
            item.px = $signed({1'b0, cfg.screen_width} - raw_x);
            item.py = $signed({1'b0, cfg.screen_height} - raw_y);
        end
        else
        begin
            item.px = $signed(raw_x);
            item.py = $signed(raw_y);
        end
        item.id   = tdata[33:30];
        item.size = tdata[49:34];
    end

endmodule

// ===== rtl/tchq_fifo.sv =====
// ----------------------------------------------------------------------------
// tchq_fifo
// Two-entry queue between the classifier and the tracker.
// ----------------------------------------------------------------------------
module tchq_fifo
    import tchq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  q_item_t     push_item,
    output logic        push_ready,
    input  logic        pop,
    output logic        pop_valid,
    output q_item_t     pop_item,
    output logic [1:0]  count
);

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/tchq_back.sv =====
// ----------------------------------------------------------------------------
// tchq_back
// Touch tracker, poll delay adaptation and output register.
// ----------------------------------------------------------------------------
module tchq_back
    import tchq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  back_cfg_t              cfg,
    input  logic                   q_valid,
    input  q_item_t                q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [1:0]             m_tuser,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                    touching_reg,   touching_next;
    logic signed [OUT_W-1:0] ref_x_reg,      ref_x_next;
    logic signed [OUT_W-1:0] ref_y_reg,      ref_y_next;
    logic signed [OUT_W-1:0] shown_x_reg,    shown_x_next;
    logic signed [OUT_W-1:0] shown_y_reg,    shown_y_next;
    logic [ID_W-1:0]         shown_id_reg,   shown_id_next;
    logic [SIZE_W-1:0]       shown_size_reg, shown_size_next;
    logic [DLY_W-1:0]        delay_reg,      delay_next;

    logic                    out_valid_reg,  out_valid_next;
    ev_kind_t                kind_reg,       kind_next;
    logic signed [OUT_W-1:0] out_x_reg,      out_x_next;
    logic signed [OUT_W-1:0] out_y_reg,      out_y_next;
    logic [ID_W-1:0]         out_id_reg,     out_id_next;
    logic [SIZE_W-1:0]       out_size_reg,   out_size_next;
    logic [DLY_W-1:0]        out_delay_reg,  out_delay_next;

    logic signed [OUT_W:0]   diff_x;
    logic signed [OUT_W:0]   diff_y;
    logic [OUT_W:0]          abs_x;
    logic [OUT_W:0]          abs_y;
    logic                    moved;
    logic [DLY_W:0]          dly_pre;
    logic [DLY_W:0]          dly_lo;

    // Advance when the output register is free or being emptied
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    assign diff_x = {q_item.px[OUT_W-1], q_item.px} - {ref_x_reg[OUT_W-1], ref_x_reg};
    assign diff_y = {q_item.py[OUT_W-1], q_item.py} - {ref_y_reg[OUT_W-1], ref_y_reg};
    assign abs_x  = diff_x[OUT_W] ? $unsigned(-diff_x) : $unsigned(diff_x);
    assign abs_y  = diff_y[OUT_W] ? $unsigned(-diff_y) : $unsigned(diff_y);
    assign moved  = (abs_x > {{(OUT_W-7){1'b0}}, cfg.move_threshold}) ||
                    (abs_y > {{(OUT_W-7){1'b0}}, cfg.move_threshold});

    // Delay: reload or grow, raise to minimum, then cap at maximum
    assign dly_pre = q_item.qualified ? {1'b0, cfg.poll_min}
                                      : {1'b0, delay_reg} + {1'b0, cfg.poll_step};
    assign dly_lo  = (dly_pre < {1'b0, cfg.poll_min}) ? {1'b0, cfg.poll_min} : dly_pre;

    always_comb
    begin
        touching_next   = touching_reg;
        ref_x_next      = ref_x_reg;
        ref_y_next      = ref_y_reg;
        shown_x_next    = shown_x_reg;
        shown_y_next    = shown_y_reg;
        shown_id_next   = shown_id_reg;
        shown_size_next = shown_size_reg;
        delay_next      = delay_reg;
        kind_next       = EV_NONE;

        if (q_item.read_ok)
        begin
            if (q_item.qualified)
            begin
                shown_x_next    = q_item.px;
                shown_y_next    = q_item.py;
                shown_id_next   = q_item.id;
                shown_size_next = q_item.size;
                touching_next   = 1'b1;
                if (!touching_reg)
                begin
                    kind_next = EV_DOWN;
                end
                else
                begin
                    kind_next  = moved ? EV_MOVE : EV_DOWN;
                    ref_x_next = q_item.px;
                    ref_y_next = q_item.py;
                end
            end
            else if (touching_reg)
            begin
                kind_next     = EV_UP;
                touching_next = 1'b0;
                ref_x_next    = '0;
                ref_y_next    = '0;
            end
            else
            begin
                shown_x_next    = '0;
                shown_y_next    = '0;
                shown_id_next   = '0;
                shown_size_next = '0;
            end
            delay_next = (dly_lo > {1'b0, cfg.poll_max}) ? cfg.poll_max : dly_lo[DLY_W-1:0];
        end

        if (kind_next == EV_NONE)
        begin
            out_x_next    = '0;
            out_y_next    = '0;
            out_id_next   = '0;
            out_size_next = '0;
        end
        else
        begin
            out_x_next    = shown_x_next;
            out_y_next    = shown_y_next;
            out_id_next   = shown_id_next;
            out_size_next = shown_size_next;
        end
        out_delay_next = delay_next;

        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touching_reg   <= 1'b0;
            ref_x_reg      <= '0;
            ref_y_reg      <= '0;
            shown_x_reg    <= '0;
            shown_y_reg    <= '0;
            shown_id_reg   <= '0;
            shown_size_reg <= '0;
            delay_reg      <= POLL_MIN_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                touching_reg   <= touching_next;
                ref_x_reg      <= ref_x_next;
                ref_y_reg      <= ref_y_next;
                shown_x_reg    <= shown_x_next;
                shown_y_reg    <= shown_y_next;
                shown_id_reg   <= shown_id_next;
                shown_size_reg <= shown_size_next;
                delay_reg      <= delay_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg      <= kind_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_id_reg    <= out_id_next;
            out_size_reg  <= out_size_next;
            out_delay_reg <= out_delay_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {2'b00, out_delay_reg, out_size_reg, out_id_reg,
                       out_y_reg, out_x_reg};

endmodule
